>>> rtl/hsv2rgb_pkg.sv
// Types, constants and arithmetic helpers for the HSV to RGB converter.
// Depends on nothing; used by the core and by its checker.
package hsv2rgb_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
  localparam int PROD_BITS    = 2 * CHANNEL_BITS;
  localparam int HS_BITS      = CHANNEL_BITS + 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PROD_BITS-1:0]    prod_t;
  typedef logic [HS_BITS-1:0]      hue6_t;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t value;
  } hsv_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Colour wheel sectors, in order round the circle
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  // floor(p / CHAN_MAX) for p <= CHAN_MAX^2: the estimate (p + p>>N) >> N is
  // low by at most one, so one compare on the remainder fixes it.
  function automatic chan_t div_by_max(input prod_t p);
    logic [PROD_BITS:0]           sum;
    logic [CHANNEL_BITS:0]        q;
    logic [PROD_BITS:0]           qx;
    logic [PROD_BITS:0]           qm;
    logic [PROD_BITS:0]           rem;
    sum = {1'b0, p} + {{(CHANNEL_BITS + 1){1'b0}}, p[PROD_BITS-1:CHANNEL_BITS]};
    q   = sum[PROD_BITS:CHANNEL_BITS];
    qx  = {{CHANNEL_BITS{1'b0}}, q};
    qm  = (qx << CHANNEL_BITS) - qx;
    rem = {1'b0, p} - qm;
    if (rem >= (PROD_BITS + 1)'(CHAN_MAX)) begin
      q = q + (CHANNEL_BITS + 1)'(1);
    end
    return q[CHANNEL_BITS-1:0];
  endfunction

  // Split hue*6 into sector and fraction; the top hue folds into the last sector
  function automatic void split_hue(input chan_t h, output sector_t sec, output chan_t frac);
    hue6_t hs;
    hue6_t rest;
    hs   = (hue6_t'(h) << 2) + (hue6_t'(h) << 1);
    sec  = SEC_R_TO_Y;
    rest = hs;
    for (int k = 1; k <= 5; k++) begin
      if (hs >= hue6_t'(k * CHAN_MAX)) begin
        sec  = sector_t'(3'(k));
        rest = hs - hue6_t'(k * CHAN_MAX);
      end
    end
    if (hs >= hue6_t'(6 * CHAN_MAX)) begin
      sec  = SEC_M_TO_R;
      rest = hue6_t'(CHAN_MAX);
    end
    frac = rest[CHANNEL_BITS-1:0];
  endfunction

endpackage

>>> rtl/hsv_to_rgb_8bit_core.sv
// HSV to RGB pixel converter, six-sector mapping in exact integer arithmetic.
// Each accepted transaction passes stages s1 to s4 and the rgb register, then shows on rgb.
// Throughput: one transaction per cycle while rgb_stall is low; five register
// stages of at most one multiply or constant division each. Stalls fill bubbles first.
// Reset (rst, synchronous) clears the stage valid bits only; data is not reset.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_8bit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output hsv2rgb_pkg::rgb_t rgb
);
  import hsv2rgb_pkg::*;

  // Stage valid bits; rgb_valid is the fifth
  logic v1, v2, v3, v4;
  // Stage advance enables: a stage loads when it is empty or its successor moves
  logic en1, en2, en3, en4, en5;

  // Stage 1: saturation * value, hue split
  prod_t   s1_prod;
  sector_t s1_sec;
  chan_t   s1_frac;
  chan_t   s1_value;
  // Stage 2: chroma, fraction coefficient
  chan_t   s2_chroma;
  chan_t   s2_coef;
  sector_t s2_sec;
  chan_t   s2_value;
  // Stage 3: chroma * coefficient, offset
  prod_t   s3_xprod;
  chan_t   s3_chroma;
  chan_t   s3_offset;
  sector_t s3_sec;
  // Stage 4: secondary value
  chan_t   s4_x;
  chan_t   s4_chroma;
  chan_t   s4_offset;
  sector_t s4_sec;

  sector_t in_sec;
  chan_t   in_frac;
  rgb_t    rgb_next;
  chan_t   pr, pg, pb;

  assign en5 = !rgb_valid || !rgb_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  // Hold the input only when every stage is full and the output is blocked
  assign hsv_stall = !en1;

  always_comb begin
    split_hue(hsv.hue, in_sec, in_frac);
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1) v1        <= hsv_valid;
      if (en2) v2        <= v1;
      if (en3) v3        <= v2;
      if (en4) v4        <= v3;
      if (en5) rgb_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod  <= prod_t'(hsv.saturation) * prod_t'(hsv.value);
      s1_sec   <= in_sec;
      s1_frac  <= in_frac;
      s1_value <= hsv.value;
    end
    if (en2) begin
      s2_chroma <= div_by_max(s1_prod);
      // Odd sectors fall away from the primary, so use one minus the fraction
      if (s1_sec == SEC_Y_TO_G || s1_sec == SEC_C_TO_B || s1_sec == SEC_M_TO_R) begin
        s2_coef <= chan_t'(CHAN_MAX) - s1_frac;
      end else begin
        s2_coef <= s1_frac;
      end
      s2_sec   <= s1_sec;
      s2_value <= s1_value;
    end
    if (en3) begin
      s3_xprod  <= prod_t'(s2_chroma) * prod_t'(s2_coef);
      s3_chroma <= s2_chroma;
      s3_offset <= s2_value - s2_chroma;
      s3_sec    <= s2_sec;
    end
    if (en4) begin
      s4_x      <= div_by_max(s3_xprod);
      s4_chroma <= s3_chroma;
      s4_offset <= s3_offset;
      s4_sec    <= s3_sec;
    end
    if (en5) begin
      rgb <= rgb_next;
    end
  end

  // Place chroma and secondary by sector, then lift all channels by the offset
  always_comb begin
    pr = '0;
    pg = '0;
    pb = '0;
    case (s4_sec)
      SEC_R_TO_Y: begin pr = s4_chroma; pg = s4_x;      end
      SEC_Y_TO_G: begin pr = s4_x;      pg = s4_chroma; end
      SEC_G_TO_C: begin pg = s4_chroma; pb = s4_x;      end
      SEC_C_TO_B: begin pg = s4_x;      pb = s4_chroma; end
      SEC_B_TO_M: begin pr = s4_x;      pb = s4_chroma; end
      default:    begin pr = s4_chroma; pb = s4_x;      end
    endcase
    rgb_next.red   = pr + s4_offset;
    rgb_next.green = pg + s4_offset;
    rgb_next.blue  = pb + s4_offset;
  end

endmodule

>>> rtl/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the core.
// Depends on hsv2rgb_pkg and hsv_to_rgb_8bit_core.
module hsv2rgb_checker (
  input logic              clk,
  input logic              rst,
  input logic              hsv_valid,
  input logic              hsv_stall,
  input hsv2rgb_pkg::hsv_t hsv,
  input logic              rgb_valid,
  input logic              rgb_stall,
  input hsv2rgb_pkg::rgb_t rgb
);
  import hsv2rgb_pkg::*;

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rgb_valid)
    else $error("result valid straight after reset");

  // Back-pressure only when the output itself is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (rgb_valid && rgb_stall))
    else $error("input stalled while output free");

  // A transaction taken while the output stays free comes out as a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall && !rgb_stall) ##1 !rgb_stall ##1 !rgb_stall
      ##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid)
    else $error("transaction lost in pipeline");

  // Blocked result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(rgb)))
    else $error("stalled result changed");

  // Stalled input transaction holds until taken
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv_stall) |=> (hsv_valid && $stable(hsv)))
    else $error("stalled input changed");

endmodule

bind hsv_to_rgb_8bit_core hsv2rgb_checker u_hsv2rgb_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for hsv_to_rgb_8bit_core: drives HSV pixels, predicts RGB
// in plain integer arithmetic and compares every result in order.
// Depends on hsv2rgb_pkg and the core RTL only.
module testbench;
  import hsv2rgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PIXELS  = 1030;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 400;
  localparam int REPORT_LIMIT   = 10;

  // Colour conversion predictor and in-order store of expected pixels
  class pixel_scoreboard;
    rgb_t expected_rgb[$];
    hsv_t source_hsv[$];
    int   failures;
    int   checked;

    function new();
      failures = 0;
      checked  = 0;
    endfunction

    function rgb_t convert_pixel(hsv_t p);
      int unsigned chroma;
      int unsigned hue6;
      int unsigned frac;
      int unsigned second;
      int unsigned offset;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      sector_t     sec;
      rgb_t        px;
      chroma = (int'(p.saturation) * int'(p.value)) / CHAN_MAX;
      hue6   = 6 * int'(p.hue);
      if (hue6 / CHAN_MAX > 5) begin
        // top hue lands on sector six: fold back so the secondary is zero
        sec  = SEC_M_TO_R;
        frac = CHAN_MAX;
      end else begin
        sec  = sector_t'(hue6 / CHAN_MAX);
        frac = hue6 - (hue6 / CHAN_MAX) * CHAN_MAX;
      end
      if (sec[0]) second = (chroma * (CHAN_MAX - frac)) / CHAN_MAX;
      else        second = (chroma * frac) / CHAN_MAX;
      case (sec)
        SEC_R_TO_Y: begin r = chroma; g = second; b = 0;      end
        SEC_Y_TO_G: begin r = second; g = chroma; b = 0;      end
        SEC_G_TO_C: begin r = 0;      g = chroma; b = second; end
        SEC_C_TO_B: begin r = 0;      g = second; b = chroma; end
        SEC_B_TO_M: begin r = second; g = 0;      b = chroma; end
        default:    begin r = chroma; g = 0;      b = second; end
      endcase
      offset   = int'(p.value) - chroma;
      px.red   = chan_t'(r + offset);
      px.green = chan_t'(g + offset);
      px.blue  = chan_t'(b + offset);
      return px;
    endfunction

    function void note_pixel(hsv_t p);
      expected_rgb.push_back(convert_pixel(p));
      source_hsv.push_back(p);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      hsv_t src;
      if (expected_rgb.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected rgb %h/%h/%h with no pixel in flight",
                   got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      src  = source_hsv.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("rgb mismatch on pixel %0d (hsv %h/%h/%h): expected %h/%h/%h, got %h/%h/%h",
                   checked, src.hue, src.saturation, src.value,
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
      checked++;
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hsv_valid = 1'b0;
  logic hsv_stall;
  hsv_t hsv = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  rgb_t rgb;

  pixel_scoreboard sb = new();

  int unsigned burst_left  = 0;
  int unsigned pixels_in   = 0;
  int unsigned idle_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned stall_mode  = 0;

  hsv_to_rgb_8bit_core dut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always #2 clk = ~clk;

  // Lean towards the ends of the range now and then; otherwise uniform
  function automatic chan_t random_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return chan_t'(CHAN_MAX);
      2:       return chan_t'($urandom_range(CHAN_MAX - 3, CHAN_MAX));
      3:       return chan_t'($urandom_range(0, 3));
      default: return chan_t'($urandom_range(0, CHAN_MAX));
    endcase
  endfunction

  // Offer one pixel and hold it until taken; then either keep the burst going
  // (valid stays high for the next transaction) or drop valid for a short gap.
  task automatic offer_pixel(input hsv_t p);
    hsv       <= p;
    hsv_valid <= 1'b1;
    do @(posedge clk); while (hsv_stall);
    sb.note_pixel(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      hsv_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic offer_hsv(input int unsigned h, input int unsigned s, input int unsigned v);
    hsv_t p;
    p.hue        = chan_t'(h);
    p.saturation = chan_t'(s);
    p.value      = chan_t'(v);
    offer_pixel(p);
  endtask

  // Receiver: check every transaction on rgb, track progress for the watchdog
  // and drive rgb_stall from a stall pattern chosen at random.
  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
    end else begin
      cycle_count++;
      if (rgb_valid && !rgb_stall) sb.check_pixel(rgb);
      if (hsv_valid && !hsv_stall) pixels_in++;

      // Reset the watchdog on any transaction in either direction
      if ((rgb_valid && !rgb_stall) || (hsv_valid && !hsv_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end

      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);

      // One long hold-off while the sender keeps offering: fills the pipe
      // so that hsv_stall must rise.
      if (!hold_done && pixels_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        rgb_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       rgb_stall <= 1'b0;
          1:       rgb_stall <= ($urandom_range(0, 3) == 0);
          2:       rgb_stall <= ($urandom_range(0, 3) != 0);
          default: rgb_stall <= cycle_count[2];
        endcase
      end
    end
  end

  initial begin
    int unsigned h;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sector edges at full saturation and brightness, top hue included
    for (int k = 0; k <= 6; k++) begin
      h = (k * CHAN_MAX) / 6;
      offer_hsv(h, CHAN_MAX, CHAN_MAX);
      if (h < CHAN_MAX) offer_hsv(h + 1, CHAN_MAX, CHAN_MAX);
    end
    offer_hsv(CHAN_MAX - 1, CHAN_MAX, CHAN_MAX);
    // Grey: no saturation, no brightness, or both
    offer_hsv(CHAN_MAX / 3, 0, CHAN_MAX - 55);
    offer_hsv(CHAN_MAX / 5, CHAN_MAX, 0);
    offer_hsv(CHAN_MAX, 0, 0);
    // Smallest non-zero chroma terms and alternating bit patterns
    offer_hsv(1, CHAN_MAX, 1);
    offer_hsv(1, 1, CHAN_MAX);
    offer_hsv(CHAN_MAX, CHAN_MAX, 1);
    offer_hsv(CHAN_MAX / 2, CHAN_MAX / 2 + 1, CHAN_MAX / 2 + 1);
    offer_hsv(CHAN_MAX / 3, CHAN_MAX / 3 * 2, CHAN_MAX / 3);
    offer_hsv(CHAN_MAX / 3 * 2, CHAN_MAX / 3, CHAN_MAX / 3 * 2);

    repeat (RANDOM_PIXELS) begin
      hsv_t p;
      p.hue        = random_channel();
      p.saturation = random_channel();
      p.value      = random_channel();
      offer_pixel(p);
    end

    // Drain: wait for every expected pixel, then allow for the pipe depth
    hsv_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
